// File: rtl/status_led_pattern_controller_defines.svh
// assertion macros shared by the status led pattern controller rtl
// expects i_clk and i_rst_n in the scope of every use
`ifndef STATUS_LED_PATTERN_CONTROLLER_DEFINES_SVH
`define STATUS_LED_PATTERN_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SLPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SLPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/slpc_pkg.sv
// shared types, codes and constants of the status led pattern controller
// no dependencies
`default_nettype none

package slpc_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [2:0] {
        PAT_NONE  = 3'd0,
        PAT_SOLID = 3'd1,
        PAT_BLINK = 3'd2,
        PAT_PULSE = 3'd3,
        PAT_FLASH = 3'd4
    } t_pattern;

    typedef enum logic [1:0] {
        ST_STARTUP   = 2'd0,
        ST_GPS_SEARCH = 2'd1,
        ST_GPS_LOCK  = 2'd2,
        ST_OTHER     = 2'd3
    } t_sys_state;

    typedef enum logic [2:0] {
        REG_BLINK_PERIOD   = 3'd0,
        REG_FADE_PERIOD    = 3'd1,
        REG_FADE_STEP      = 3'd2,
        REG_FULL_LEVEL     = 3'd3,
        REG_FLASH_LENGTH   = 3'd4
    } t_reg_idx;

    localparam logic [23:0] COL_BLUE   = 24'h0000FF;
    localparam logic [23:0] COL_GREEN  = 24'h00FF00;
    localparam logic [23:0] COL_RED    = 24'hFF0000;
    localparam logic [23:0] COL_AMBER  = 24'hFFBF00;
    localparam logic [23:0] COL_CYAN   = 24'h00BFFF;
    localparam logic [23:0] COL_ORANGE = 24'hFF8000;
    localparam logic [23:0] COL_BLACK  = 24'h000000;

    localparam logic [15:0] RST_BLINK_PERIOD   = 16'd1000;
    localparam logic [15:0] RST_FADE_PERIOD    = 16'd20;
    localparam logic [7:0]  RST_FADE_STEP      = 8'd2;
    localparam logic [7:0]  RST_FULL_LEVEL     = 8'd50;
    localparam logic [15:0] RST_FLASH_LENGTH   = 16'd200;

    typedef struct packed {
        logic [15:0] blink_period;
        logic [15:0] fade_period;
        logic [7:0]  fade_step;
        logic [7:0]  full_level;
        logic [15:0] flash_length;
    } t_cfg;

    typedef struct packed {
        logic [3:0] error_flags;
        logic [3:0] warning_flags;
        logic [2:0] event_flags;
        logic [1:0] system_state;
    } t_item;

    typedef struct packed {
        logic [23:0] led_color;
        logic [7:0]  led_level;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/slpc_regs.sv
// apb configuration registers of the status led pattern controller
// depends on slpc_pkg
`default_nettype none

module slpc_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [slpc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [slpc_pkg::DATA_W-1:0] pwdata,
    output logic      [slpc_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output slpc_pkg::t_cfg                   o_cfg
);
    import slpc_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (idx)
                REG_BLINK_PERIOD:   n_cfg.blink_period   = pwdata[15:0];
                REG_FADE_PERIOD:    n_cfg.fade_period    = pwdata[15:0];
                REG_FADE_STEP:      n_cfg.fade_step      = pwdata[7:0];
                REG_FULL_LEVEL:     n_cfg.full_level     = pwdata[7:0];
                REG_FLASH_LENGTH:   n_cfg.flash_length   = pwdata[15:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_BLINK_PERIOD:   prdata = {16'd0, r_cfg.blink_period};
            REG_FADE_PERIOD:    prdata = {16'd0, r_cfg.fade_period};
            REG_FADE_STEP:      prdata = {24'd0, r_cfg.fade_step};
            REG_FULL_LEVEL:     prdata = {24'd0, r_cfg.full_level};
            REG_FLASH_LENGTH:   prdata = {16'd0, r_cfg.flash_length};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blink_period   <= RST_BLINK_PERIOD;
            r_cfg.fade_period    <= RST_FADE_PERIOD;
            r_cfg.fade_step      <= RST_FADE_STEP;
            r_cfg.full_level     <= RST_FULL_LEVEL;
            r_cfg.flash_length   <= RST_FLASH_LENGTH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/slpc_engine.sv
// indication state and per-tick pattern logic of the status led pattern controller
// depends on slpc_pkg and status_led_pattern_controller_defines.svh
`default_nettype none
`include "status_led_pattern_controller_defines.svh"

module slpc_engine (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  slpc_pkg::t_item      i_item,
    input  slpc_pkg::t_cfg       i_cfg,
    output logic                 o_res_valid,
    output slpc_pkg::t_result    o_res
);
    import slpc_pkg::*;

    // indication state
    logic [31:0] r_tick;
    t_pattern    r_pat;
    logic [23:0] r_col;
    logic [15:0] r_dur;
    logic [31:0] r_start;
    logic [31:0] r_blink_mark;
    logic [31:0] r_fade_mark;
    logic [7:0]  r_level;
    logic        r_rising;

    t_pattern    n_pat;
    logic [23:0] n_col;
    logic [15:0] n_dur;
    logic [31:0] n_start;
    logic [31:0] n_blink_mark;
    logic [31:0] n_fade_mark;
    logic [7:0]  n_level;
    logic        n_rising;

    logic [31:0] start_el;
    logic        hold;
    logic        expire;
    t_pattern    pat_c;
    logic [23:0] col_c;
    logic [15:0] dur_c;
    logic [31:0] start_c;

    logic        sel_valid;
    t_pattern    sel_pat;
    logic [23:0] sel_col;
    logic [15:0] sel_dur;
    logic        restart;

    logic [7:0]  lvl_s;
    logic        rise_s;
    logic [31:0] blink_el;
    logic [31:0] fade_el;
    logic [31:0] flash_el;
    logic [8:0]  up_sum;

    // a running flash holds, an expired one clears
    always_comb begin
        start_el = r_tick - r_start;
        hold     = (r_dur != 16'd0) && (start_el < {16'd0, r_dur});
        expire   = (r_dur != 16'd0) && !hold;
        pat_c    = expire ? PAT_NONE : r_pat;
        col_c    = expire ? COL_BLACK : r_col;
        dur_c    = expire ? 16'd0 : r_dur;
        start_c  = expire ? 32'd0 : r_start;
    end

    // priority pick: errors, warnings, events, then system state
    always_comb begin
        sel_valid = 1'b1;
        sel_pat   = PAT_SOLID;
        sel_col   = COL_BLACK;
        sel_dur   = 16'd0;
        if (i_item.error_flags != 4'd0) begin
            sel_col = COL_RED;
            if (i_item.error_flags[0])      sel_pat = PAT_SOLID;
            else if (i_item.error_flags[1]) sel_pat = PAT_BLINK;
            else if (i_item.error_flags[2]) sel_pat = PAT_PULSE;
            else                            sel_valid = 1'b0;
        end else if (i_item.warning_flags != 4'd0) begin
            sel_col = COL_AMBER;
            if (i_item.warning_flags[0])      sel_pat = PAT_SOLID;
            else if (i_item.warning_flags[1]) sel_pat = PAT_BLINK;
            else if (i_item.warning_flags[2]) sel_pat = PAT_PULSE;
            else                              sel_valid = 1'b0;
        end else if (i_item.event_flags != 3'd0) begin
            sel_pat = PAT_FLASH;
            sel_dur = i_cfg.flash_length;
            if (i_item.event_flags[0])      sel_col = COL_ORANGE;
            else if (i_item.event_flags[1]) sel_col = COL_CYAN;
            else                            sel_valid = 1'b0;
        end else begin
            case (t_sys_state'(i_item.system_state))
                ST_STARTUP: begin
                    sel_pat = PAT_SOLID;
                    sel_col = COL_BLUE;
                end
                ST_GPS_SEARCH: begin
                    sel_pat = PAT_PULSE;
                    sel_col = COL_BLUE;
                end
                ST_GPS_LOCK: begin
                    sel_pat = PAT_SOLID;
                    sel_col = COL_GREEN;
                end
                default: begin
                    sel_pat = PAT_SOLID;
                    sel_col = COL_BLACK;
                end
            endcase
        end
    end

    // restart phase only on a different indication
    always_comb begin
        restart = !hold && sel_valid
                  && ((sel_pat != pat_c) || (sel_col != col_c) || (sel_dur != dur_c));
        n_pat        = restart ? sel_pat : pat_c;
        n_col        = restart ? sel_col : col_c;
        n_dur        = restart ? sel_dur : dur_c;
        n_start      = restart ? r_tick : start_c;
        lvl_s        = restart ? 8'd0 : r_level;
        rise_s       = restart ? 1'b1 : r_rising;
        blink_el     = restart ? 32'd0 : (r_tick - r_blink_mark);
        fade_el      = restart ? 32'd0 : (r_tick - r_fade_mark);
        flash_el     = restart ? 32'd0 : (r_tick - start_c);
    end

    // drive the led from the active pattern
    always_comb begin
        n_blink_mark = restart ? r_tick : r_blink_mark;
        n_fade_mark  = restart ? r_tick : r_fade_mark;
        n_level      = lvl_s;
        n_rising     = rise_s;
        o_res_valid  = 1'b0;
        o_res.led_color = n_col;
        o_res.led_level = i_cfg.full_level;
        up_sum       = {1'b0, lvl_s} + {1'b0, i_cfg.fade_step};
        case (n_pat)
            PAT_SOLID: begin
                o_res_valid = 1'b1;
            end
            PAT_BLINK: begin
                if (blink_el >= {16'd0, i_cfg.blink_period}) begin
                    n_blink_mark = r_tick;
                    n_level      = (lvl_s == 8'd0) ? i_cfg.full_level : 8'd0;
                    o_res_valid  = 1'b1;
                end
            end
            PAT_PULSE: begin
                if (fade_el >= {16'd0, i_cfg.fade_period}) begin
                    n_fade_mark = r_tick;
                    o_res_valid = 1'b1;
                    if (rise_s) begin
                        if (up_sum > {1'b0, i_cfg.full_level}) begin
                            n_level  = i_cfg.full_level;
                            n_rising = 1'b0;
                        end else begin
                            n_level = up_sum[7:0];
                        end
                    end else begin
                        if (lvl_s < i_cfg.fade_step) begin
                            n_level  = 8'd0;
                            n_rising = 1'b1;
                        end else begin
                            n_level = lvl_s - i_cfg.fade_step;
                        end
                    end
                end
            end
            PAT_FLASH: begin
                o_res_valid = flash_el < {16'd0, n_dur};
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
        if (n_pat == PAT_BLINK || n_pat == PAT_PULSE) begin
            o_res.led_level = n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= 32'd0;
            r_pat        <= PAT_NONE;
            r_col        <= COL_BLACK;
            r_dur        <= 16'd0;
            r_start      <= 32'd0;
            r_blink_mark <= 32'd0;
            r_fade_mark  <= 32'd0;
            r_level      <= 8'd0;
            r_rising     <= 1'b1;
        end else if (i_fire) begin
            r_tick       <= r_tick + 32'd1;
            r_pat        <= n_pat;
            r_col        <= n_col;
            r_dur        <= n_dur;
            r_start      <= n_start;
            r_blink_mark <= n_blink_mark;
            r_fade_mark  <= n_fade_mark;
            r_level      <= n_level;
            r_rising     <= n_rising;
        end
    end

    `SLPC_ASSERT_SAME(a_dur_only_flash, r_dur != 16'd0, r_pat == PAT_FLASH, "timed non-flash")
    `SLPC_ASSERT_SAME(a_none_dark, r_pat == PAT_NONE, {r_col, r_dur} == 40'd0, "no pattern lit")
    `SLPC_ASSERT_NEXT(a_tick_adv, i_fire, r_tick == $past(r_tick) + 32'd1, "tick did not advance")

endmodule

`default_nettype wire

// File: rtl/status_led_pattern_controller.sv
// top level of the status led pattern controller: input register, engine, result register
// depends on slpc_pkg, slpc_regs, slpc_engine and status_led_pattern_controller_defines.svh
// a tick waits in the input register until the result register is free or draining, then
// a tick with a led write loads it and raises o_valid; throughput: one tick per cycle while
// no led write stalls; a stalled one holds the tick behind it: two transactions at most
// reset: synchronous active low; restores register defaults, clears tick time and indication
`default_nettype none
`include "status_led_pattern_controller_defines.svh"

module status_led_pattern_controller (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // tick transaction in
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [3:0]                  i_error_flags,
    input  wire logic [3:0]                  i_warning_flags,
    input  wire logic [2:0]                  i_event_flags,
    input  wire logic [1:0]                  i_system_state,
    // led write transaction out
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic      [23:0]                 o_led_color,
    output logic      [7:0]                  o_led_level,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [slpc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [slpc_pkg::DATA_W-1:0] pwdata,
    output logic      [slpc_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import slpc_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    logic    n_in_valid;
    t_result r_res;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result eng_res;
    logic    eng_res_valid;
    logic    in_accept;
    logic    fire;

    slpc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // the held tick is processed once the result register is free or draining;
    // a new tick enters in the same cycle, while a stalled result holds both
    assign fire      = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || fire;
    assign in_accept = i_valid && o_ready;

    slpc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_item),
        .i_cfg       (cfg),
        .o_res_valid (eng_res_valid),
        .o_res       (eng_res)
    );

    always_comb begin
        n_in_valid  = in_accept ? 1'b1 : (fire ? 1'b0 : r_in_valid);
        n_out_valid = fire ? eng_res_valid : (r_out_valid && !i_ready);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.error_flags   <= i_error_flags;
            r_item.warning_flags <= i_warning_flags;
            r_item.event_flags   <= i_event_flags;
            r_item.system_state  <= i_system_state;
        end
        if (fire && eng_res_valid) begin
            r_res <= eng_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_led_color = r_res.led_color;
    assign o_led_level = r_res.led_level;

    `SLPC_ASSERT_NEXT(a_in_taken, in_accept, r_in_valid, "accepted tick lost")
    `SLPC_ASSERT_NEXT(a_res_taken, fire && eng_res_valid, r_out_valid, "led write lost")
    `SLPC_ASSERT_NEXT(a_out_hold, r_out_valid && !i_ready, r_out_valid && $stable(r_res), "held write")

endmodule

`default_nettype wire

// File: tb/slpc_led_checker.sv
// scoreboard for the status led pattern controller: tracks register writes, predicts every
// led write from the accepted ticks and compares it with what the block puts out
// depends on slpc_pkg
`default_nettype none

module slpc_led_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic                        o_ready,
    input  wire logic [3:0]                  i_error_flags,
    input  wire logic [3:0]                  i_warning_flags,
    input  wire logic [2:0]                  i_event_flags,
    input  wire logic [1:0]                  i_system_state,
    input  wire logic                        o_valid,
    input  wire logic                        i_ready,
    input  wire logic [23:0]                 o_led_color,
    input  wire logic [7:0]                  o_led_level,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [slpc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [slpc_pkg::DATA_W-1:0] pwdata,
    input  wire logic [slpc_pkg::DATA_W-1:0] prdata,
    input  wire logic                        pready,
    output int                               fail_count,
    output int                               pending_writes,
    output int                               checked_writes
);
    import slpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg        cfg;
    logic [31:0] tick_now;
    logic [31:0] pat_start;
    logic [31:0] blink_mark;
    logic [31:0] fade_mark;
    t_pattern    act_pat;
    logic [23:0] act_col;
    logic [15:0] act_dur;
    logic [7:0]  lvl;
    logic        rising;
    t_result     expected_writes[$];

    // a new indication restarts the phase, the same one leaves it running
    task automatic choose_indication(t_pattern pat, logic [23:0] col, logic [15:0] dur,
                                     logic [31:0] now);
        if (act_pat == pat && act_col == col && act_dur == dur)
            return;
        act_pat    = pat;
        act_col    = col;
        act_dur    = dur;
        pat_start  = now;
        blink_mark = now;
        fade_mark  = now;
        lvl        = '0;
        rising     = 1'b1;
    endtask

    task automatic drive_led(logic [31:0] now);
        logic [8:0] sum;
        logic       hit;
        logic [7:0] out_lvl;
        t_result    wr;
        hit     = 1'b0;
        out_lvl = '0;
        sum     = {1'b0, lvl} + {1'b0, cfg.fade_step};
        case (act_pat)
            PAT_SOLID: begin
                hit     = 1'b1;
                out_lvl = cfg.full_level;
            end
            PAT_BLINK: begin
                if (now - blink_mark >= 32'(cfg.blink_period)) begin
                    blink_mark = now;
                    lvl        = (lvl == 8'd0) ? cfg.full_level : 8'd0;
                    hit        = 1'b1;
                    out_lvl    = lvl;
                end
            end
            PAT_PULSE: begin
                if (now - fade_mark >= 32'(cfg.fade_period)) begin
                    fade_mark = now;
                    if (rising) begin
                        if (sum > {1'b0, cfg.full_level}) begin
                            lvl    = cfg.full_level;
                            rising = 1'b0;
                        end else begin
                            lvl = sum[7:0];
                        end
                    end else begin
                        if (lvl < cfg.fade_step) begin
                            lvl    = '0;
                            rising = 1'b1;
                        end else begin
                            lvl = lvl - cfg.fade_step;
                        end
                    end
                    hit     = 1'b1;
                    out_lvl = lvl;
                end
            end
            PAT_FLASH: begin
                if (now - pat_start < 32'(act_dur)) begin
                    hit     = 1'b1;
                    out_lvl = cfg.full_level;
                end
            end
            default: ;
        endcase
        if (hit) begin
            wr.led_color = act_col;
            wr.led_level = out_lvl;
            expected_writes.push_back(wr);
        end
    endtask

    task automatic predict_led_write(t_item tk);
        logic [31:0] now;
        now      = tick_now;
        tick_now = tick_now + 32'd1;
        // a running flash holds off every other request until it runs out
        if (act_dur != 16'd0) begin
            if (now - pat_start < 32'(act_dur)) begin
                drive_led(now);
                return;
            end
            act_pat   = PAT_NONE;
            act_col   = '0;
            act_dur   = '0;
            pat_start = '0;
        end
        if (tk.error_flags != 4'd0) begin
            if (tk.error_flags[0])      choose_indication(PAT_SOLID, COL_RED, 16'd0, now);
            else if (tk.error_flags[1]) choose_indication(PAT_BLINK, COL_RED, 16'd0, now);
            else if (tk.error_flags[2]) choose_indication(PAT_PULSE, COL_RED, 16'd0, now);
        end else if (tk.warning_flags != 4'd0) begin
            if (tk.warning_flags[0])      choose_indication(PAT_SOLID, COL_AMBER, 16'd0, now);
            else if (tk.warning_flags[1]) choose_indication(PAT_BLINK, COL_AMBER, 16'd0, now);
            else if (tk.warning_flags[2]) choose_indication(PAT_PULSE, COL_AMBER, 16'd0, now);
        end else if (tk.event_flags != 3'd0) begin
            if (tk.event_flags[0])
                choose_indication(PAT_FLASH, COL_ORANGE, cfg.flash_length, now);
            else if (tk.event_flags[1])
                choose_indication(PAT_FLASH, COL_CYAN, cfg.flash_length, now);
        end else begin
            case (t_sys_state'(tk.system_state))
                ST_STARTUP:    choose_indication(PAT_SOLID, COL_BLUE, 16'd0, now);
                ST_GPS_SEARCH: choose_indication(PAT_PULSE, COL_BLUE, 16'd0, now);
                ST_GPS_LOCK:   choose_indication(PAT_SOLID, COL_GREEN, 16'd0, now);
                default:       choose_indication(PAT_SOLID, COL_BLACK, 16'd0, now);
            endcase
        end
        drive_led(now);
    endtask

    always @(posedge i_clk) begin : monitor
        t_item       tk;
        t_result     want;
        logic [31:0] reg_val;
        if (!i_rst_n) begin
            cfg.blink_period   = RST_BLINK_PERIOD;
            cfg.fade_period    = RST_FADE_PERIOD;
            cfg.fade_step      = RST_FADE_STEP;
            cfg.full_level     = RST_FULL_LEVEL;
            cfg.flash_length   = RST_FLASH_LENGTH;
            tick_now   = '0;
            pat_start  = '0;
            blink_mark = '0;
            fade_mark  = '0;
            act_pat    = PAT_NONE;
            act_col    = '0;
            act_dur    = '0;
            lvl        = '0;
            rising     = 1'b1;
            expected_writes.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (expected_writes.size() == 0) begin
                    $error("led write with none expected: led_color %06h led_level %0d",
                           o_led_color, o_led_level);
                    fail_count++;
                end else begin
                    want = expected_writes.pop_front();
                    if (o_led_color !== want.led_color) begin
                        $error("led_color mismatch: expected %06h, actual %06h",
                               want.led_color, o_led_color);
                        fail_count++;
                    end
                    if (o_led_level !== want.led_level) begin
                        $error("led_level mismatch: expected %0d, actual %0d",
                               want.led_level, o_led_level);
                        fail_count++;
                    end
                    checked_writes++;
                end
            end
            if (i_valid && o_ready) begin
                tk.error_flags   = i_error_flags;
                tk.warning_flags = i_warning_flags;
                tk.event_flags   = i_event_flags;
                tk.system_state  = i_system_state;
                predict_led_write(tk);
            end
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (t_reg_idx'(paddr[ADDR_W-1:2]))
                        REG_BLINK_PERIOD:   cfg.blink_period   = pwdata[15:0];
                        REG_FADE_PERIOD:    cfg.fade_period    = pwdata[15:0];
                        REG_FADE_STEP:      cfg.fade_step      = pwdata[7:0];
                        REG_FULL_LEVEL:     cfg.full_level     = pwdata[7:0];
                        REG_FLASH_LENGTH:   cfg.flash_length   = pwdata[15:0];
                        default: ;
                    endcase
                end else begin
                    case (t_reg_idx'(paddr[ADDR_W-1:2]))
                        REG_BLINK_PERIOD:   reg_val = 32'(cfg.blink_period);
                        REG_FADE_PERIOD:    reg_val = 32'(cfg.fade_period);
                        REG_FADE_STEP:      reg_val = 32'(cfg.fade_step);
                        REG_FULL_LEVEL:     reg_val = 32'(cfg.full_level);
                        REG_FLASH_LENGTH:   reg_val = 32'(cfg.flash_length);
                        default:            reg_val = prdata;
                    endcase
                    if (prdata !== reg_val) begin
                        $error("prdata mismatch at paddr %0h: expected %08h, actual %08h",
                               paddr, reg_val, prdata);
                        fail_count++;
                    end
                end
            end
        end
        pending_writes <= expected_writes.size();
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
// top of the status led pattern controller testbench: clock, reset, tick stimulus,
// led write back-pressure and register programming; verdict from the checker's count
// depends on slpc_pkg, slpc_led_checker and status_led_pattern_controller
`default_nettype none

module tb;
    import slpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // generous bound: ~2000 ticks plus holds and register traffic
    localparam int LIMIT = 200000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [3:0]        i_error_flags = '0;
    logic [3:0]        i_warning_flags = '0;
    logic [2:0]        i_event_flags = '0;
    logic [1:0]        i_system_state = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [23:0]       o_led_color;
    logic [7:0]        o_led_level;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending_writes;
    int checked_writes;
    int snd_idle = 0;       // percent chance of a gap before a tick
    int rcv_stall = 0;      // percent chance the led side is not ready
    bit long_hold = 1'b0;   // asks the led side for one long stall
    int ticks_sent = 0;
    int settings_used = 0;
    int cyc;

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    status_led_pattern_controller dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_error_flags   (i_error_flags),
        .i_warning_flags (i_warning_flags),
        .i_event_flags   (i_event_flags),
        .i_system_state  (i_system_state),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_led_color     (o_led_color),
        .o_led_level     (o_led_level),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    slpc_led_checker led_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_error_flags   (i_error_flags),
        .i_warning_flags (i_warning_flags),
        .i_event_flags   (i_event_flags),
        .i_system_state  (i_system_state),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_led_color     (o_led_color),
        .o_led_level     (o_led_level),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .pending_writes  (pending_writes),
        .checked_writes  (checked_writes)
    );

    // led side: random back-pressure, or one long stall on request so that the
    // block's output fills and it has to stop taking ticks
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
            end else begin
                i_ready <= (rcv_stall == 0) || ($urandom_range(99) >= rcv_stall);
            end
        end
    end

    // one tick transaction; valid stays up with a steady payload until accepted
    task automatic send_tick(logic [3:0] err, logic [3:0] warn, logic [2:0] evt,
                             t_sys_state st);
        if (snd_idle != 0 && $urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_error_flags   <= err;
        i_warning_flags <= warn;
        i_event_flags   <= evt;
        i_system_state  <= st;
        do @(posedge i_clk); while (!o_ready);
        ticks_sent++;
    endtask

    // setup cycle then access cycle; pready ends the access
    task automatic apb_xfer(bit wr, t_reg_idx idx, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write every register, with junk above its width, and read each one back
    task automatic set_cfg(logic [15:0] blink, logic [15:0] fade, logic [7:0] step,
                           logic [7:0] top, logic [15:0] flash);
        logic [15:0] vals [5];
        logic [31:0] mask;
        logic [31:0] wdata;
        t_reg_idx    idx;
        vals = '{blink, fade, 16'(step), 16'(top), flash};
        for (int r = 0; r < 5; r++) begin
            idx   = t_reg_idx'(r);
            mask  = (idx == REG_FADE_STEP || idx == REG_FULL_LEVEL) ?
                    32'h0000_00FF : 32'h0000_FFFF;
            wdata = ($urandom() & ~mask) | (32'(vals[r]) & mask);
            apb_xfer(1'b1, idx, wdata);
            apb_xfer(1'b0, idx, '0);
        end
        settings_used++;
    endtask

    // stop offering ticks until every predicted write is out; a tick that writes
    // nothing may still sit in the two-stage pipe, so the task idles on to let that pipe empty
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_writes != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // runs of one request with random content, so blink and pulse get to cycle,
    // salted with fully random ticks
    task automatic random_ticks(int n);
        int         sent;
        int         run_len;
        int         pick;
        logic [3:0] e;
        logic [3:0] w;
        logic [2:0] v;
        t_sys_state s;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(99);
            e = '0;
            w = '0;
            v = '0;
            s = t_sys_state'($urandom_range(3));
            if (pick < 12)      e = 4'($urandom_range(1, 15));
            else if (pick < 24) w = 4'($urandom_range(1, 15));
            else if (pick < 40) v = 3'($urandom_range(1, 7));
            run_len = $urandom_range(1, 30);
            for (int k = 0; k < run_len && sent < n; k++) begin
                if ($urandom_range(99) < 10)
                    send_tick(4'($urandom_range(15)), 4'($urandom_range(15)),
                              3'($urandom_range(7)), t_sys_state'($urandom_range(3)));
                else
                    send_tick(e, w, v, s);
                sent++;
            end
        end
    endtask

    // timeout guard
    initial begin
        cyc = 0;
        while (cyc < LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("timeout after %0d cycles", cyc);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int bm;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short periods and a 3-tick flash so each case shows quickly
        set_cfg(16'd2, 16'd1, 8'd20, 8'd50, 16'd3);
        // state colours; the repeat must not restart the pattern
        send_tick(4'd0, 4'd0, 3'd0, ST_STARTUP);
        send_tick(4'd0, 4'd0, 3'd0, ST_STARTUP);
        // pulse climbs past the top, clamps and turns down
        repeat (4) send_tick(4'd0, 4'd0, 3'd0, ST_GPS_SEARCH);
        send_tick(4'd0, 4'd0, 3'd0, ST_GPS_LOCK);
        send_tick(4'd0, 4'd0, 3'd0, ST_OTHER);
        // errors in priority order, then the unmapped one keeps the pulse going
        send_tick(4'b0001, 4'd0, 3'd0, ST_STARTUP);
        repeat (3) send_tick(4'b0010, 4'd0, 3'd0, ST_STARTUP);
        send_tick(4'b0100, 4'd0, 3'd0, ST_STARTUP);
        send_tick(4'b1000, 4'd0, 3'd0, ST_STARTUP);
        send_tick(4'b1111, 4'b1111, 3'b111, ST_OTHER);
        // warnings, the last one unmapped
        send_tick(4'd0, 4'b0001, 3'd0, ST_STARTUP);
        send_tick(4'd0, 4'b0010, 3'd0, ST_STARTUP);
        send_tick(4'd0, 4'b0100, 3'd0, ST_STARTUP);
        send_tick(4'd0, 4'b1000, 3'd0, ST_STARTUP);
        // rx flash holds over later events, expires, then the unmapped event
        // leaves nothing lit and a tx flash starts
        send_tick(4'd0, 4'd0, 3'b001, ST_STARTUP);
        send_tick(4'd0, 4'd0, 3'b010, ST_STARTUP);
        send_tick(4'd0, 4'd0, 3'b100, ST_STARTUP);
        send_tick(4'd0, 4'd0, 3'b100, ST_STARTUP);
        send_tick(4'd0, 4'd0, 3'b010, ST_STARTUP);
        drain();

        // random phases over several settings and idling mixes
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_cfg(16'd3, 16'd2, 8'd7, 8'd60, 16'd10);
                1: set_cfg(16'd1, 16'd1, 8'd1, 8'd1, 16'd1);
                // periods of zero act every tick, the step overshoots the top,
                // and a zero flash length never lights
                2: set_cfg(16'd0, 16'd0, 8'd200, 8'd100, 16'd0);
                // largest values last, since a long flash outlasts the phase
                7: set_cfg(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
                default: begin
                    bm = $urandom_range(1, 255);
                    set_cfg(16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
                            8'($urandom_range(1, bm)), 8'(bm), 16'($urandom_range(1, 20)));
                end
            endcase
            case (ph % 4)
                0: begin snd_idle = 0;  rcv_stall = 0;  end
                1: begin snd_idle = 65; rcv_stall = 0;  end
                2: begin snd_idle = 0;  rcv_stall = 65; end
                default: begin snd_idle = 9; rcv_stall = 9; end
            endcase
            if (ph == 3) begin
                // keep offering solid ticks through a long led stall, then pause
                long_hold = 1'b1;
                repeat (40) send_tick(4'd0, 4'd0, 3'd0, ST_STARTUP);
                drain();
            end
            random_ticks(245);
            drain();
        end

        $display("sent %0d tick transactions over %0d register settings",
                 ticks_sent, settings_used);
        $display("checked %0d led write transactions", checked_writes);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
